>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the RTL. Empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset
`define ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked at every rising edge outside reset
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLY(lbl, ck, rs, ante, cons)
`define ASSERT_NEXT(lbl, ck, rs, ante, cons)

`endif

`endif

>>> rtl/core/msdp_pkg.sv
// ----------------------------------------------------------------------------
// msdp_pkg
// Types and constants of the masked-share dot product online block.
// ----------------------------------------------------------------------------
package msdp_pkg;

  localparam int WORD_W      = 64;
  localparam int HALF_W      = WORD_W / 2;
  localparam int PID_W       = 3;
  localparam int NUM_PARTIES = 5;
  localparam int NUM_OTHERS  = NUM_PARTIES - 1;
  localparam int SLOT_W      = $clog2(NUM_OTHERS);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [PID_W-1:0]  pid_t;

  // party identifiers
  localparam pid_t PID_1 = 3'd1;
  localparam pid_t PID_2 = 3'd2;
  localparam pid_t PID_3 = 3'd3;
  localparam pid_t PID_4 = 3'd4;
  localparam pid_t PID_5 = 3'd5;

  // result kinds
  localparam logic KIND_MSG   = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  typedef enum logic [1:0] {
    REQ_ELEM   = 2'd0,
    REQ_OFFSET = 2'd1,
    REQ_CLOSE  = 2'd2,
    REQ_RECV   = 2'd3
  } req_t;

  // control that travels alongside the product lanes
  typedef struct packed {
    logic  valid;
    req_t  req;
    word_t rx;
  } ctl_t;

  typedef struct packed {
    pid_t  dest;
    word_t value;
  } msg_t;

  // group of result words caused by one input word
  typedef struct packed {
    logic                        valid;
    logic                        kind;
    logic [SLOT_W-1:0]           last;
    msg_t [NUM_OTHERS-1:0]       msg;
    word_t                       addend;
  } bundle_t;

endpackage

>>> rtl/core/msdp_lane.sv
// ----------------------------------------------------------------------------
// msdp_lane
// Two-stage 64x64 modulo 2^64 multiplier built from 32x32 partial products,
// with a pass mode that forwards operand a unchanged.
// ----------------------------------------------------------------------------
module msdp_lane (
  input  logic           clk,
  input  logic           en,
  input  logic           pass,
  input  msdp_pkg::word_t a,
  input  msdp_pkg::word_t b,
  output msdp_pkg::word_t prod
);
  import msdp_pkg::*;

  word_t             mul_ll;
  word_t             ll;
  logic [HALF_W-1:0] c_lo;
  logic [HALF_W-1:0] c_hi;

  assign mul_ll = word_t'(a[HALF_W-1:0]) * word_t'(b[HALF_W-1:0]);

  // Stage one: low product and the two cross products (low halves only)
  always_ff @(posedge clk) begin
    if (en) begin
      if (pass) begin
        ll   <= a;
        c_lo <= '0;
        c_hi <= '0;
      end else begin
        ll   <= mul_ll;
        c_lo <= a[HALF_W-1:0] * b[WORD_W-1:HALF_W];
        c_hi <= a[WORD_W-1:HALF_W] * b[HALF_W-1:0];
      end
    end
  end

  // Stage two: fold the cross terms into the upper half
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= ll + {c_lo + c_hi, {HALF_W{1'b0}}};
    end
  end

endmodule

>>> rtl/core/msdp_state.sv
// ----------------------------------------------------------------------------
// msdp_state
// Per-party partial accumulators and beta product sum; builds the close
// messages and the two halves of the final sum.
// ----------------------------------------------------------------------------
module msdp_state (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        en,
  input  msdp_pkg::pid_t                              me,
  input  msdp_pkg::ctl_t                              ctl,
  input  msdp_pkg::word_t [msdp_pkg::NUM_OTHERS-1:0]  u,
  input  msdp_pkg::word_t [msdp_pkg::NUM_OTHERS-1:0]  v,
  input  msdp_pkg::word_t                             w,
  output msdp_pkg::bundle_t                           pre
);
  import msdp_pkg::*;

  word_t [NUM_PARTIES-1:0] partials;
  word_t [NUM_PARTIES-1:0] partials_next;
  word_t [NUM_PARTIES-1:0] masked;
  word_t                   bps;
  word_t                   bps_next;
  bundle_t                 pre_next;

  // Update the accumulators: each other party takes its lane in id order
  always_comb begin
    logic [SLOT_W-1:0] slot;
    partials_next = partials;
    bps_next      = bps;
    slot          = '0;
    if (ctl.valid) begin
      case (ctl.req)
        REQ_ELEM, REQ_OFFSET: begin
          for (int i = 0; i < NUM_PARTIES; i++) begin
            if (pid_t'(i + 1) != me) begin
              slot = (pid_t'(i + 1) < me) ? SLOT_W'(i) : SLOT_W'(i - 1);
              if (ctl.req == REQ_ELEM) begin
                partials_next[i] = partials[i] - u[slot] - v[slot];
              end else begin
                partials_next[i] = partials[i] + u[slot] + v[slot];
              end
            end
          end
          if (ctl.req == REQ_ELEM) begin
            bps_next = bps + w;
          end
        end
        REQ_RECV: begin
          partials_next = '0;
          bps_next      = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Drop our own partial from the final sum
  always_comb begin
    for (int i = 0; i < NUM_PARTIES; i++) begin
      masked[i] = (pid_t'(i + 1) == me) ? '0 : partials[i];
    end
  end

  // Build the result group for close and receive words
  always_comb begin
    pre_next       = '0;
    pre_next.valid = ctl.valid && (ctl.req == REQ_CLOSE || ctl.req == REQ_RECV);
    case (ctl.req)
      REQ_CLOSE: begin
        pre_next.kind = KIND_MSG;
        case (me)
          PID_1: begin
            pre_next.msg[0] = '{dest: PID_4, value: partials[3]};
            pre_next.msg[1] = '{dest: PID_5, value: partials[4]};
            pre_next.msg[2] = '{dest: PID_2, value: partials[1]};
            pre_next.msg[3] = '{dest: PID_3, value: partials[2]};
            pre_next.last   = SLOT_W'(3);
          end
          PID_2: begin
            pre_next.msg[0] = '{dest: PID_4, value: partials[3]};
            pre_next.msg[1] = '{dest: PID_5, value: partials[4]};
            pre_next.last   = SLOT_W'(1);
          end
          PID_3: begin
            pre_next.msg[0] = '{dest: PID_4, value: partials[3]};
            pre_next.msg[1] = '{dest: PID_5, value: partials[4]};
            pre_next.msg[2] = '{dest: PID_1, value: partials[0]};
            pre_next.last   = SLOT_W'(2);
          end
          default: begin
            // parties four and five
            pre_next.msg[0] = '{dest: PID_2, value: partials[1]};
            pre_next.msg[1] = '{dest: PID_3, value: partials[2]};
            pre_next.msg[2] = '{dest: PID_1, value: partials[0]};
            pre_next.last   = SLOT_W'(2);
          end
        endcase
      end
      REQ_RECV: begin
        pre_next.kind         = KIND_FINAL;
        pre_next.last         = '0;
        pre_next.msg[0].dest  = me;
        pre_next.msg[0].value = masked[0] + masked[1] + masked[2];
        pre_next.addend       = masked[3] + masked[4] + ctl.rx + bps;
      end
      default: begin
      end
    endcase
  end

  // Advance state and result group together with the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      partials <= '0;
      bps      <= '0;
      pre      <= '0;
    end else if (en) begin
      partials <= partials_next;
      bps      <= bps_next;
      pre      <= pre_next;
    end
  end

endmodule

>>> rtl/core/msdp_out.sv
// ----------------------------------------------------------------------------
// msdp_out
// Output register holding one result group; hands its words out one per
// accepted transfer and stalls the pipeline until the group drains.
// ----------------------------------------------------------------------------
module msdp_out (
  input  logic                clk,
  input  logic                rst,
  input  msdp_pkg::bundle_t   pre,
  input  logic                out_ready,
  output logic                adv,
  output logic                out_valid,
  output logic                kind,
  output logic [2:0]          dest_party,
  output logic [2:0]          op_offset,
  output logic [63:0]         value,
  output logic                last_out
);
  import msdp_pkg::*;

  bundle_t           grp;
  bundle_t           grp_next;
  logic [SLOT_W-1:0] idx;
  logic              last_word;
  msg_t              cur;

  // Finish the final sum on the way into the output register
  always_comb begin
    grp_next              = pre;
    grp_next.msg[0].value = pre.msg[0].value + pre.addend;
    grp_next.addend       = '0;
  end

  assign last_word = (idx == grp.last);
  assign adv       = !grp.valid || (out_ready && last_word);
  assign cur       = grp.msg[idx];

  // Load a new group when the current one is done, else step through it
  always_ff @(posedge clk) begin
    if (rst) begin
      grp <= '0;
      idx <= '0;
    end else if (adv) begin
      grp <= grp_next;
      idx <= '0;
    end else if (out_ready) begin
      idx <= idx + SLOT_W'(1);
    end
  end

  assign out_valid  = grp.valid;
  assign kind       = grp.kind;
  assign dest_party = cur.dest;
  assign op_offset  = cur.dest - PID_1;
  assign value      = cur.value;
  assign last_out   = last_word;

endmodule

>>> rtl/core/masked_share_dot_product_online.sv
// ----------------------------------------------------------------------------
// masked_share_dot_product_online
// Online phase of a five-party masked-share dot product, modulo 2^64.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (req_type plus payload) enter on in_valid/in_ready; result
//   words leave on out_valid/out_ready; party_id is written on cfg_valid
//   with cfg_data (always ready, values outside 1..5 are dropped).
//   Element and offset words give no result. A close word gives two to four
//   partial words, a receive word gives one final word and clears the sums.
//   The pipeline has five register stages: input, partial products, full
//   products, accumulators, output. A result word is presented once its
//   input word has passed through these stages in order.
//   Throughput is one input word per cycle while no result group is held
//   back; the output register holds one result group, and the pipeline
//   holds while a close group drains. The 64x64 products are split into
//   three 32x32 partial products each, nine lanes in parallel. A stalled
//   receiver freezes every stage while a group waits; in_ready drops with it.
//   Reset clears all sums, empties the pipeline and sets party_id to 1.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module masked_share_dot_product_online (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [63:0] beta_x,
  input  logic [63:0] beta_y,
  input  logic [63:0] alpha_x_a,
  input  logic [63:0] alpha_x_b,
  input  logic [63:0] alpha_x_c,
  input  logic [63:0] alpha_x_d,
  input  logic [63:0] alpha_y_a,
  input  logic [63:0] alpha_y_b,
  input  logic [63:0] alpha_y_c,
  input  logic [63:0] alpha_y_d,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [2:0]  dest_party,
  output logic [2:0]  op_offset,
  output logic [63:0] value,
  output logic        last_out
);
  import msdp_pkg::*;

  pid_t                     party_id;
  logic                     adv;
  ctl_t                     ctl1;
  ctl_t                     ctl2;
  ctl_t                     ctl3;
  word_t                    by1;
  word_t [NUM_OTHERS-1:0]   ax1;
  word_t [NUM_OTHERS-1:0]   ay1;
  logic                     pass1;
  word_t [NUM_OTHERS-1:0]   u_prod;
  word_t [NUM_OTHERS-1:0]   v_prod;
  word_t                    w_prod;
  bundle_t                  pre;

  // Configuration: accept only party ids 1..5
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      party_id <= PID_1;
    end else if (cfg_valid && cfg_data != '0 && cfg_data <= PID_W'(NUM_PARTIES)) begin
      party_id <= cfg_data;
    end
  end

  // Input register
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
    end else if (adv) begin
      ctl1.valid <= in_valid;
      ctl1.req   <= req_t'(req_type);
      ctl1.rx    <= beta_x;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      by1      <= beta_y;
      ax1      <= {alpha_x_d, alpha_x_c, alpha_x_b, alpha_x_a};
      ay1      <= {alpha_y_d, alpha_y_c, alpha_y_b, alpha_y_a};
    end
  end

  assign pass1 = (ctl1.req == REQ_OFFSET);

  // Product lanes: u = bx*ay, v = by*ax per other party; offset words pass
  for (genvar k = 0; k < NUM_OTHERS; k++) begin : g_lane
    msdp_lane u_lane (
      .clk  (clk),
      .en   (adv),
      .pass (pass1),
      .a    (pass1 ? ax1[k] : ctl1.rx),
      .b    (ay1[k]),
      .prod (u_prod[k])
    );
    msdp_lane v_lane (
      .clk  (clk),
      .en   (adv),
      .pass (pass1),
      .a    (pass1 ? ay1[k] : by1),
      .b    (ax1[k]),
      .prod (v_prod[k])
    );
  end

  msdp_lane w_lane (
    .clk  (clk),
    .en   (adv),
    .pass (1'b0),
    .a    (ctl1.rx),
    .b    (by1),
    .prod (w_prod)
  );

  // Carry control alongside the two lane stages
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2 <= '0;
      ctl3 <= '0;
    end else if (adv) begin
      ctl2 <= ctl1;
      ctl3 <= ctl2;
    end
  end

  msdp_state u_state (
    .clk (clk),
    .rst (rst),
    .en  (adv),
    .me  (party_id),
    .ctl (ctl3),
    .u   (u_prod),
    .v   (v_prod),
    .w   (w_prod),
    .pre (pre)
  );

  msdp_out u_out (
    .clk        (clk),
    .rst        (rst),
    .pre        (pre),
    .out_ready  (out_ready),
    .adv        (adv),
    .out_valid  (out_valid),
    .kind       (kind),
    .dest_party (dest_party),
    .op_offset  (op_offset),
    .value      (value),
    .last_out   (last_out)
  );

  // Pipeline may only take a word when the output group is finishing
  `ASSERT_IMPLY(a_ready_drain, clk, rst, in_ready && out_valid, out_ready && last_out)
  // A group keeps presenting words until its last one is taken
  `ASSERT_NEXT(a_group_cont, clk, rst, out_valid && out_ready && !last_out, out_valid)
  // The final word stands alone
  `ASSERT_IMPLY(a_final_single, clk, rst, out_valid && kind == KIND_FINAL, last_out)
  // Party id stays within the five parties
  `ASSERT_IMPLY(a_pid_range, clk, rst, 1'b1, party_id != '0 && party_id <= PID_5)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the online masked-share dot product block. It keeps
// its own copy of the per-party partial sums and the beta product sum, works
// out the partial and final words each input word should cause, and compares
// every result word field by field. Directed words cover the field extremes,
// every request type, each party id, rejected party ids and a party change in
// the middle of a vector. Random vectors with bursty input and a stalling
// receiver follow.
// ----------------------------------------------------------------------------
module tb_top;
  import msdp_pkg::*;

  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_WORDS = 414;

  typedef struct {
    req_t  req;
    word_t bx;
    word_t by;
    word_t ax [NUM_OTHERS];
    word_t ay [NUM_OTHERS];
  } share_word_t;

  typedef struct packed {
    logic       kind;
    pid_t       dest;
    logic [2:0] op_off;
    word_t      value;
    logic       last;
  } result_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = '0;
  logic [63:0] beta_x = '0;
  logic [63:0] beta_y = '0;
  logic [63:0] alpha_x_a = '0;
  logic [63:0] alpha_x_b = '0;
  logic [63:0] alpha_x_c = '0;
  logic [63:0] alpha_x_d = '0;
  logic [63:0] alpha_y_a = '0;
  logic [63:0] alpha_y_b = '0;
  logic [63:0] alpha_y_c = '0;
  logic [63:0] alpha_y_d = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic        kind;
  logic [2:0]  dest_party;
  logic [2:0]  op_offset;
  logic [63:0] value;
  logic        last_out;

  // expected-side copy of the block state
  pid_t  node_pid;
  word_t peer_partial [1:NUM_PARTIES];
  word_t beta_prod_acc;
  result_word_t pending_results [$];

  int errors = 0;
  int items_sent = 0;
  int burst_left = 0;
  bit sender_gaps = 1'b0;
  bit recv_stalls = 1'b0;
  bit ready_hold = 1'b0;
  int run_left = 0;
  int stall_left = 0;

  masked_share_dot_product_online dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .beta_x     (beta_x),
    .beta_y     (beta_y),
    .alpha_x_a  (alpha_x_a),
    .alpha_x_b  (alpha_x_b),
    .alpha_x_c  (alpha_x_c),
    .alpha_x_d  (alpha_x_d),
    .alpha_y_a  (alpha_y_a),
    .alpha_y_b  (alpha_y_b),
    .alpha_y_c  (alpha_y_c),
    .alpha_y_d  (alpha_y_d),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .dest_party (dest_party),
    .op_offset  (op_offset),
    .value      (value),
    .last_out   (last_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Expected state and results
  // ---------------------------------------------------------------------------
  function automatic void clear_share_sums();
    for (int q = 1; q <= NUM_PARTIES; q++) peer_partial[q] = '0;
    beta_prod_acc = '0;
  endfunction

  function automatic result_word_t partial_msg(pid_t dest);
    result_word_t r;
    r.kind   = KIND_MSG;
    r.dest   = dest;
    r.op_off = dest - PID_1;
    r.value  = peer_partial[dest];
    r.last   = 1'b0;
    return r;
  endfunction

  // Advance the sums by one accepted word and queue the words it causes
  function automatic void advance_share_sums(share_word_t w);
    int           slot;
    result_word_t msgs [$];
    result_word_t fin;
    word_t        total;
    slot = 0;
    case (w.req)
      REQ_ELEM, REQ_OFFSET: begin
        for (int q = 1; q <= NUM_PARTIES; q++) begin
          if (q != node_pid && slot < NUM_OTHERS) begin
            if (w.req == REQ_ELEM)
              peer_partial[q] = peer_partial[q] - w.bx * w.ay[slot] - w.by * w.ax[slot];
            else
              peer_partial[q] = peer_partial[q] + w.ax[slot] + w.ay[slot];
            slot++;
          end
        end
        if (w.req == REQ_ELEM) beta_prod_acc = beta_prod_acc + w.bx * w.by;
      end
      REQ_CLOSE: begin
        if (node_pid <= PID_3) begin
          msgs = {msgs, partial_msg(PID_4)};
          msgs = {msgs, partial_msg(PID_5)};
        end
        if (node_pid == PID_1 || node_pid == PID_4 || node_pid == PID_5) begin
          msgs = {msgs, partial_msg(PID_2)};
          msgs = {msgs, partial_msg(PID_3)};
        end
        if (node_pid >= PID_3) msgs = {msgs, partial_msg(PID_1)};
        if (msgs.size() > 0) msgs[msgs.size()-1].last = 1'b1;
        foreach (msgs[i]) pending_results = {pending_results, msgs[i]};
      end
      default: begin
        total = w.bx + beta_prod_acc;
        for (int q = 1; q <= NUM_PARTIES; q++)
          if (q != node_pid) total = total + peer_partial[q];
        fin.kind   = KIND_FINAL;
        fin.dest   = node_pid;
        fin.op_off = node_pid - PID_1;
        fin.value  = total;
        fin.last   = 1'b1;
        pending_results = {pending_results, fin};
        clear_share_sums();
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    result_word_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: value %h dest %0d", value, dest_party);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("kind", 64'(exp_r.kind), 64'(kind));
        check_field("dest_party", 64'(exp_r.dest), 64'(dest_party));
        check_field("op_offset", 64'(exp_r.op_off), 64'(op_offset));
        check_field("value", exp_r.value, value);
        check_field("last_out", 64'(exp_r.last), 64'(last_out));
      end
    end
  end

  // Receiver: alternate stall and run stretches while stalls are on
  always @(negedge clk) begin
    if (rst || ready_hold || !recv_stalls) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (run_left > 0) begin
      out_ready <= 1'b1;
      run_left--;
    end else begin
      run_left = $urandom_range(0, 7);
      stall_left = $urandom_range(0, 11);
      out_ready <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic word_t rand_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return word_t'($urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic share_word_t random_word(req_t r);
    share_word_t w;
    w.req = r;
    w.bx  = rand_operand();
    w.by  = rand_operand();
    for (int i = 0; i < NUM_OTHERS; i++) begin
      w.ax[i] = rand_operand();
      w.ay[i] = rand_operand();
    end
    return w;
  endfunction

  function automatic share_word_t flat_word(req_t r, word_t v);
    share_word_t w;
    w.req = r;
    w.bx  = v;
    w.by  = v;
    for (int i = 0; i < NUM_OTHERS; i++) begin
      w.ax[i] = v;
      w.ay[i] = v;
    end
    return w;
  endfunction

  // Send one input word; on an empty burst open a new one, gapped if gaps are on
  task automatic send_word(share_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = sender_gaps ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid  <= 1'b1;
    req_type  <= w.req;
    beta_x    <= w.bx;
    beta_y    <= w.by;
    alpha_x_a <= w.ax[0];
    alpha_x_b <= w.ax[1];
    alpha_x_c <= w.ax[2];
    alpha_x_d <= w.ax[3];
    alpha_y_a <= w.ay[0];
    alpha_y_b <= w.ay[1];
    alpha_y_c <= w.ay[2];
    alpha_y_d <= w.ay[3];
    do @(posedge clk); while (!in_ready);
    advance_share_sums(w);
    items_sent++;
  endtask

  // Drop valid, wait for every expected word, then let the pipeline empty
  task automatic drain_pipe();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    ready_hold = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    ready_hold = 1'b0;
  endtask

  task automatic write_party(logic [2:0] pid);
    drain_pipe();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= pid;
    do @(posedge clk); while (!cfg_ready);
    if (pid >= PID_1 && pid <= PID_5) node_pid = pid;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Party 1 after reset: field extremes, offset shares, four partials, final
  task automatic test_reset_party();
    share_word_t w;
    send_word(flat_word(REQ_ELEM, '0));
    send_word(flat_word(REQ_ELEM, '1));
    w = flat_word(REQ_ELEM, '1);
    w.bx = '0;
    w.ax[1] = 64'h8000_0000_0000_0001;
    send_word(w);
    send_word(flat_word(REQ_OFFSET, '1));
    send_word(flat_word(REQ_CLOSE, '0));
    send_word(flat_word(REQ_RECV, '1));
  endtask

  // Each remaining party id: peer selection and final destination
  task automatic test_close_each_party();
    pid_t ids [4] = '{PID_2, PID_3, PID_4, PID_5};
    foreach (ids[i]) begin
      write_party(ids[i]);
      send_word(random_word(REQ_ELEM));
      send_word(random_word(REQ_CLOSE));
      send_word(random_word(REQ_RECV));
    end
  endtask

  // Out-of-range ids are dropped and party 3 stays in force
  task automatic test_bad_party_ids();
    write_party(PID_3);
    write_party(3'd0);
    write_party(3'd6);
    write_party(3'd7);
    send_word(random_word(REQ_CLOSE));
    send_word(random_word(REQ_RECV));
  endtask

  // Change the id mid-vector; a repeated close leaves the sums alone
  task automatic test_party_change_midvector();
    write_party(PID_2);
    send_word(random_word(REQ_ELEM));
    write_party(PID_4);
    send_word(random_word(REQ_ELEM));
    send_word(random_word(REQ_CLOSE));
    send_word(random_word(REQ_CLOSE));
    send_word(random_word(REQ_RECV));
  endtask

  // Mostly whole vectors with random content, some loose words in between
  task automatic test_random_vectors();
    int n;
    recv_stalls = 1'b1;
    sender_gaps = 1'b1;
    while (items_sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 3) == 0) begin
        sender_gaps = 1'($urandom_range(0, 1));
        recv_stalls = 1'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) send_word(random_word(req_t'($urandom_range(0, 3))));
      end else begin
        if ($urandom_range(0, 3) == 0) write_party(3'($urandom_range(0, 7)));
        n = $urandom_range(1, 8);
        repeat (n) send_word(random_word(REQ_ELEM));
        if ($urandom_range(0, 7) == 0) begin
          write_party(3'($urandom_range(1, 5)));
          send_word(random_word(REQ_ELEM));
        end
        if ($urandom_range(0, 9) < 7) send_word(random_word(REQ_OFFSET));
        if ($urandom_range(0, 9) < 9) send_word(random_word(REQ_CLOSE));
        send_word(random_word(REQ_RECV));
      end
    end
  endtask

  initial begin
    node_pid = PID_1;
    clear_share_sums();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_party();
    test_close_each_party();
    test_bad_party_ids();
    test_party_change_midvector();
    test_random_vectors();
    drain_pipe();
    if (errors == 0)
      $display("PASS masked_share_dot_product_online");
    else
      $display("FAIL masked_share_dot_product_online");
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("FAIL masked_share_dot_product_online");
    $finish;
  end

endmodule

>>> masked_share_dot_product_online.f
+incdir+rtl/core
rtl/core/msdp_pkg.sv
rtl/core/msdp_lane.sv
rtl/core/msdp_state.sv
rtl/core/msdp_out.sv
rtl/core/masked_share_dot_product_online.sv
tb/tb_top.sv
